/* rtl/nco_complex_mixer_core_assert.svh */
// Assertion macros used by the checker file of the NCO mixer.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef NCO_COMPLEX_MIXER_CORE_ASSERT_SVH
`define NCO_COMPLEX_MIXER_CORE_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define NCOMIX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define NCOMIX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ncomix_pkg.sv */
// Shared types, constants and the arctangent table of the NCO mixer.
// No dependencies; every module file imports this package.
package ncomix_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int PORT_PHASE_W = 32;
  localparam int ANGLE_W     = 32;
  localparam int PHASE_W_DEF = 32;
  localparam int STAGES_DEF  = 16;
  localparam int GAIN_FRAC   = 24;
  localparam int INV_GAIN_Q24 = 10188014;
  // Datapath width: sample, gain fraction, CORDIC growth and rounding headroom.
  localparam int DW          = SAMPLE_W + GAIN_FRAC + 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INCREMENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PHASE     = 2'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
    logic                       restart;
  } ncomix_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
    logic [PORT_PHASE_W-1:0]    next_phase;
  } ncomix_out_t;

  // One slot of the rotation chain.
  typedef struct packed {
    logic                      valid;
    logic signed [DW-1:0]      x;
    logic signed [DW-1:0]      y;
    logic signed [ANGLE_W-1:0] z;
    logic [PORT_PHASE_W-1:0]   next_phase;
  } ncomix_vec_t;

  // atan(2^-k) in units of 2^-32 turn, rounded.
  function automatic logic [ANGLE_W-1:0] ncomix_atan(input int unsigned k);
    logic [ANGLE_W-1:0] a;
    case (k)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/ncomix_front.sv */
// Front cell of the NCO mixer: phase accumulator, quadrant pre-rotation
// and inverse-gain scaling. Depends on ncomix_pkg.
module ncomix_front import ncomix_pkg::*; #(
  parameter int PHASE_WIDTH = PHASE_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  take,
  input  ncomix_in_t            in_data,
  input  logic [CFG_DATA_W-1:0] incr,
  input  logic [CFG_DATA_W-1:0] start,
  output ncomix_vec_t           q
);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  localparam logic signed [GAIN_FRAC:0] INV_S = (GAIN_FRAC + 1)'(INV_GAIN_Q24);

  logic [PHASE_WIDTH-1:0]     acc_r;
  logic [PHASE_WIDTH-1:0]     acc_nxt;
  logic [PHASE_WIDTH-1:0]     used;
  logic [PHASE_WIDTH-1:0]     inc_ext;
  logic [PHASE_WIDTH-1:0]     start_ext;
  logic [ANGLE_W-1:0]         a32;
  quad_t                      quad;
  logic signed [SAMPLE_W:0]   si_ext;
  logic signed [SAMPLE_W:0]   sq_ext;
  logic signed [SAMPLE_W:0]   xs;
  logic signed [SAMPLE_W:0]   ys;
  logic signed [DW-1:0]       px;
  logic signed [DW-1:0]       py;
  ncomix_vec_t                vec_r;
  ncomix_vec_t                vec_nxt;

  assign inc_ext   = PHASE_WIDTH'(signed'(incr));
  assign start_ext = PHASE_WIDTH'(start);
  assign used      = in_data.restart ? start_ext : acc_r;
  assign acc_nxt   = used + inc_ext;

  // Align the phase to 32 bits per turn whatever the accumulator width.
  assign a32  = ANGLE_W'({used, {ANGLE_W{1'b0}}} >> PHASE_WIDTH);
  assign quad = quad_t'(a32[ANGLE_W-1 -: 2]);

  assign si_ext = (SAMPLE_W + 1)'(in_data.sample_i);
  assign sq_ext = (SAMPLE_W + 1)'(in_data.sample_q);

  // Whole quarter turns are applied exactly before the micro-rotations.
  always_comb begin
    case (quad)
      QUAD_0: begin
        xs = si_ext;
        ys = sq_ext;
      end
      QUAD_1: begin
        xs = -sq_ext;
        ys = si_ext;
      end
      QUAD_2: begin
        xs = -si_ext;
        ys = -sq_ext;
      end
      QUAD_3: begin
        xs = sq_ext;
        ys = -si_ext;
      end
      default: begin
        xs = si_ext;
        ys = sq_ext;
      end
    endcase
  end

  assign px = xs * INV_S;
  assign py = ys * INV_S;

  always_comb begin
    vec_nxt.valid      = take;
    vec_nxt.x          = px;
    vec_nxt.y          = py;
    vec_nxt.z          = signed'({2'b00, a32[ANGLE_W-3:0]});
    vec_nxt.next_phase = PORT_PHASE_W'(acc_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      vec_r.valid <= 1'b0;
    end else begin
      if (take) begin
        acc_r <= acc_nxt;
      end
      if (en) begin
        vec_r <= vec_nxt;
      end
    end
  end

  assign q = vec_r;

endmodule

/* rtl/ncomix_cell.sv */
// One CORDIC micro-rotation cell of the NCO mixer chain.
// Depends on ncomix_pkg for the slot type and the arctangent table.
module ncomix_cell import ncomix_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  ncomix_vec_t d,
  output ncomix_vec_t q
);

  localparam logic signed [ANGLE_W-1:0] ATAN = signed'(ncomix_atan(STAGE));

  ncomix_vec_t          vec_r;
  ncomix_vec_t          vec_nxt;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;

  // Arithmetic shifts round toward minus infinity.
  assign dx = d.y >>> STAGE;
  assign dy = d.x >>> STAGE;

  always_comb begin
    vec_nxt = d;
    if (d.z >= 0) begin
      vec_nxt.x = d.x - dx;
      vec_nxt.y = d.y + dy;
      vec_nxt.z = d.z - ATAN;
    end else begin
      vec_nxt.x = d.x + dx;
      vec_nxt.y = d.y - dy;
      vec_nxt.z = d.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r.valid <= 1'b0;
    end else if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign q = vec_r;

endmodule

/* rtl/ncomix_out.sv */
// Output cell of the NCO mixer: rounding, saturation and the result register.
// Depends on ncomix_pkg.
module ncomix_out import ncomix_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  ncomix_vec_t d,
  output logic        out_valid,
  output ncomix_out_t out_data
);

  localparam int RW = DW - GAIN_FRAC;
  localparam logic signed [DW-1:0] HALF = DW'(1) <<< (GAIN_FRAC - 1);

  logic signed [DW-1:0]       xr;
  logic signed [DW-1:0]       yr;
  logic signed [SAMPLE_W-1:0] si;
  logic signed [SAMPLE_W-1:0] sq;
  logic                       valid_r;
  ncomix_out_t                data_r;
  ncomix_out_t                data_nxt;

  assign xr = d.x + HALF;
  assign yr = d.y + HALF;

  // The value fits when all bits above the sample's sign bit agree with it.
  function automatic logic signed [SAMPLE_W-1:0] sat(input logic [RW-1:0] r);
    logic signed [SAMPLE_W-1:0] s;
    if (&r[RW-1:SAMPLE_W-1] || ~|r[RW-1:SAMPLE_W-1]) begin
      s = signed'(r[SAMPLE_W-1:0]);
    end else if (r[RW-1]) begin
      s = signed'({1'b1, {(SAMPLE_W - 1){1'b0}}});
    end else begin
      s = signed'({1'b0, {(SAMPLE_W - 1){1'b1}}});
    end
    return s;
  endfunction

  assign si = sat(xr[DW-1:GAIN_FRAC]);
  assign sq = sat(yr[DW-1:GAIN_FRAC]);

  always_comb begin
    data_nxt.out_i      = si;
    data_nxt.out_q      = sq;
    data_nxt.next_phase = d.next_phase;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* rtl/nco_complex_mixer_core.sv */
// NCO complex mixer: an accepted sample passes the front register, the chain of
// ROTATION_STAGES micro-rotation cells and the output register; one sample per cycle
// sustained while no result is held. The whole chain holds while a result waits
// under out_stall. Synchronous active-low reset clears the configuration registers,
// the phase accumulator and every valid bit in the chain.
module nco_complex_mixer_core import ncomix_pkg::*; #(
  parameter int PHASE_WIDTH     = PHASE_W_DEF,
  parameter int ROTATION_STAGES = STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ncomix_in_t            in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ncomix_out_t           out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                  en;
  logic                  take;
  logic [CFG_DATA_W-1:0] incr_r;
  logic [CFG_DATA_W-1:0] start_r;
  ncomix_vec_t           chain [0:ROTATION_STAGES];

  // The chain advances unless a finished result is being held back.
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign take      = in_valid && en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      incr_r  <= '0;
      start_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_INCREMENT: incr_r  <= cfg_data;
        REG_START_PHASE:     start_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ncomix_front #(
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .take    (take),
    .in_data (in_data),
    .incr    (incr_r),
    .start   (start_r),
    .q       (chain[0])
  );

  for (genvar k = 0; k < ROTATION_STAGES; k++) begin : g_cell
    ncomix_cell #(
      .STAGE (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (chain[k]),
      .q     (chain[k+1])
    );
  end

  ncomix_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .d         (chain[ROTATION_STAGES]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* rtl/ncomix_checker.sv */
// Port-level checker for the NCO mixer, bound to nco_complex_mixer_core.
// Depends on ncomix_pkg and the assertion macro header.
`include "nco_complex_mixer_core_assert.svh"

module ncomix_checker import ncomix_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input ncomix_out_t out_data
);

  logic out_held;

  assign out_held = out_valid && out_stall;

  // A held result must stay put until the transaction completes.
  `NCOMIX_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "held result changed")

  // A held result must back up the input side.
  `NCOMIX_ASSERT_NOW(a_backpressure, out_held, in_stall, "input taken while result held")

  // The input side is only stalled while a result is waiting.
  `NCOMIX_ASSERT_NOW(a_stall_cause, in_stall, out_held, "input stalled without a held result")

endmodule

bind nco_complex_mixer_core ncomix_checker u_checker (.*);

/* dv/nco_complex_mixer_core_tb.sv */
// Self-checking testbench for nco_complex_mixer_core: directed and random I/Q samples
// with random idling on both channels, checked against an in-bench CORDIC predictor.
// Depends on rtl/ncomix_pkg.sv and rtl/nco_complex_mixer_core.sv.
module nco_complex_mixer_core_tb;
  import ncomix_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 150;
  localparam int MAX_REPORTS = 10;

  // Register indexes that the block decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  class mixer_scoreboard;
    localparam longint UNITY_Q24 = 10188014;
    localparam int FRAC_BITS = 24;
    localparam int CHAIN_LEN = 16;

    logic [31:0] phase_step;
    logic [31:0] start_phase;
    logic [31:0] phase_acc;
    longint atan_step[CHAIN_LEN];
    ncomix_out_t due_results[$];
    int unsigned mismatches;

    function new();
      phase_step = '0;
      start_phase = '0;
      phase_acc = '0;
      mismatches = 0;
      atan_step = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                    83443, 41722, 20861};
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_PHASE_INCREMENT: phase_step = val;
        REG_START_PHASE: start_phase = val;
        default: ;
      endcase
    endfunction

    function logic signed [SAMPLE_W-1:0] round_to_sample(longint v);
      longint r;
      longint hi;
      hi = (longint'(1) << (SAMPLE_W - 1)) - 1;
      r = (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > hi) r = hi;
      if (r < -hi - 1) r = -hi - 1;
      return r[SAMPLE_W-1:0];
    endfunction

    function void rotate_sample(logic signed [SAMPLE_W-1:0] si, logic signed [SAMPLE_W-1:0] sq,
                                logic [31:0] angle, output logic signed [SAMPLE_W-1:0] oi,
                                output logic signed [SAMPLE_W-1:0] oq);
      longint x, y, z, t, dx, dy;
      x = longint'(si) * UNITY_Q24;
      y = longint'(sq) * UNITY_Q24;
      z = longint'(angle[29:0]);
      // Whole quarter turns are applied exactly before the micro-rotations.
      case (angle[31:30])
        2'd1: begin
          t = x; x = -y; y = t;
        end
        2'd2: begin
          x = -x; y = -y;
        end
        2'd3: begin
          t = x; x = y; y = -t;
        end
        default: ;
      endcase
      for (int k = 0; k < CHAIN_LEN; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - atan_step[k];
        end else begin
          x = x + dx; y = y - dy; z = z + atan_step[k];
        end
      end
      oi = round_to_sample(x);
      oq = round_to_sample(y);
    endfunction

    function void note_sample(ncomix_in_t s);
      ncomix_out_t e;
      logic [31:0] angle;
      angle = s.restart ? start_phase : phase_acc;
      rotate_sample(s.sample_i, s.sample_q, angle, e.out_i, e.out_q);
      phase_acc = angle + phase_step;
      e.next_phase = phase_acc;
      due_results.push_back(e);
    endfunction

    function void check_result(ncomix_out_t got);
      ncomix_out_t e;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: i=%0d q=%0d phase=%h",
                   got.out_i, got.out_q, got.next_phase);
        return;
      end
      e = due_results.pop_front();
      if (got.out_i !== e.out_i || got.out_q !== e.out_q || got.next_phase !== e.next_phase) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected i=%0d q=%0d phase=%h, got i=%0d q=%0d phase=%h",
                   e.out_i, e.out_q, e.next_phase, got.out_i, got.out_q, got.next_phase);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ncomix_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ncomix_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit steady = 1'b0;
  int unsigned quiet_cycles = 0;
  mixer_scoreboard sb = new();

  nco_complex_mixer_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (steady) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 32);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog: any transaction on any channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // All driving tasks start and end at a falling edge.
  task automatic send_iq(logic signed [SAMPLE_W-1:0] si, logic signed [SAMPLE_W-1:0] sq,
                         logic restart);
    ncomix_in_t s;
    s.sample_i = si;
    s.sample_q = sq;
    s.restart = restart;
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (sb.due_results.size() != 0) @(negedge clk);
  endtask

  task automatic program_regs(logic [31:0] step, logic [31:0] start_val, bit probe_spare);
    wait_idle();
    put_reg(REG_PHASE_INCREMENT, step);
    put_reg(REG_START_PHASE, start_val);
    if (probe_spare) begin
      put_reg(REG_SPARE_A, $urandom());
      put_reg(REG_SPARE_B, $urandom());
    end
    cfg_valid <= 1'b0;
  endtask

  // Full-range values half the time, with extremes and small values mixed in.
  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    int unsigned kind;
    logic [31:0] r;
    int m;
    kind = $urandom_range(0, 9);
    r = $urandom();
    if (kind < 5) return r[SAMPLE_W-1:0];
    if (kind < 7) begin
      case ($urandom_range(0, 5))
        0: return 16'sh8000;
        1: return 16'sh8001;
        2: return -16'sd1;
        3: return 16'sd0;
        4: return 16'sd1;
        default: return 16'sh7FFF;
      endcase
    end
    m = int'($urandom_range(0, 2047)) - 1024;
    return m[SAMPLE_W-1:0];
  endfunction

  initial begin
    logic [31:0] step;
    logic [31:0] start_val;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Eighth-turn steps walk full-scale samples through every quadrant;
    // the diagonal ones saturate.
    program_regs(32'h2000_0000, 32'h0000_0000, 1'b0);
    for (int k = 0; k < 8; k++) send_iq(16'sh7FFF, 16'sh7FFF, k == 0);
    for (int k = 0; k < 8; k++) send_iq(16'sh8000, 16'sh8000, k == 0);
    send_iq(16'sd0, 16'sd0, 1'b0);
    send_iq(16'sh8000, 16'sh7FFF, 1'b0);
    send_iq(16'sd1, -16'sd1, 1'b1);
    send_iq(16'sh7FFF, 16'sh8000, 1'b0);
    in_valid <= 1'b0;

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          step = 32'h7FFF_FFFF; start_val = 32'hFFFF_FFFF;
        end
        1: begin
          step = 32'h8000_0000; start_val = 32'h4000_0000;
        end
        2: begin
          step = 32'hFFFF_FFFF; start_val = 32'h8000_0000;
        end
        3: begin
          step = 32'h0000_0000; start_val = $urandom();
        end
        4: begin
          step = $urandom_range(1, 1 << 20); start_val = $urandom();
        end
        5: begin
          step = -$urandom_range(1, 1 << 24); start_val = 32'hC000_0000;
        end
        default: begin
          step = $urandom(); start_val = $urandom();
        end
      endcase
      program_regs(step, start_val, p == 5);
      steady = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_iq(pick_value(), pick_value(), (n == 0) || ($urandom_range(0, 11) == 0));
      in_valid <= 1'b0;
      steady = 1'b0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* nco_complex_mixer_core.f */
+incdir+rtl
rtl/ncomix_pkg.sv
rtl/ncomix_front.sv
rtl/ncomix_cell.sv
rtl/ncomix_out.sv
rtl/nco_complex_mixer_core.sv
rtl/ncomix_checker.sv
dv/nco_complex_mixer_core_tb.sv
